FILE: src/stencil_star_9point_2d_defines.svh
// ----------------------------------------------------------------------------
// stencil_star_9point_2d_defines
// assertion macros used by the checker file of the stencil block
// ----------------------------------------------------------------------------
`ifndef STENCIL_STAR_9POINT_2D_DEFINES_SVH
`define STENCIL_STAR_9POINT_2D_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SST_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("stencil check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SST_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("stencil check failed");

`endif

FILE: src/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// shared widths, register codes, types and weight function of the stencil
// ----------------------------------------------------------------------------
package sst_pkg;

  // field widths
  localparam int DATA_W     = 32;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 13;
  localparam int GW_W       = 14;
  localparam int GH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // reset values and limits
  localparam logic [GW_W-1:0] GRID_WIDTH_RST  = 14'd4100;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RST = 16'd4100;
  localparam int MIN_DIM   = 5;
  localparam int ROW_SLOTS = 4;
  localparam int NUM_TAPS  = 9;

  // parameter defaults
  localparam int MAX_WIDTH_DEF  = 8192;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUTQ_DEPTH_DEF = 8;

  // grid size as seen by the window logic
  typedef struct packed {
    logic [GW_W-1:0] width;
    logic [GH_W-1:0] height;
  } geom_t;

  // per-result side information
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } tag_t;

  // weight k/10 as an unsigned fraction, rounded to nearest
  function automatic int unsigned weight(input int unsigned k, input int unsigned frac);
    return ((k << frac) + 32'd5) / 32'd10;
  endfunction

endpackage

FILE: src/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// simple dual-port ram, one write and one registered read, read-first
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: src/sst_linebuf.sv
// ----------------------------------------------------------------------------
// sst_linebuf
// raster counters, four-row line store and window taps feeding the mac
// ----------------------------------------------------------------------------
module sst_linebuf #(
  parameter int MAX_WIDTH = sst_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sst_pkg::geom_t                    geom_i,
  input  logic                              accept_i,
  input  logic signed [sst_pkg::DATA_W-1:0] sample_i,
  output logic                              emit_o,
  output logic                              op_valid_o,
  output logic signed [sst_pkg::DATA_W-1:0] ops_o [sst_pkg::NUM_TAPS],
  output sst_pkg::tag_t                     op_tag_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > sst_pkg::GW_W) ? WW : sst_pkg::GW_W;
  localparam int DW = sst_pkg::DATA_W;
  localparam int HW = sst_pkg::GH_W;
  localparam int LW = sst_pkg::ROW_SLOTS * DW;

  logic [EW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] col_q, col_d, cur_c;
  logic [HW-1:0] row_q, row_d, cur_r;
  logic [HW:0]   r_inc, r_nx;
  logic [EW-1:0] c_nx, c_m2;
  logic          c_wrap, last;

  logic              s1_valid_q, s1_emit_q;
  logic [CW-1:0]     s1_addr_q;
  logic [1:0]        s1_slot_q;
  logic [DW-1:0]     s1_sample_q;
  sst_pkg::tag_t     s1_tag_q;

  logic [LW-1:0] rdata, wdata;
  logic [DW-1:0] col [5];
  logic [DW-1:0] crt_q [5];
  logic [DW-1:0] cdt_q [8];
  logic          op_valid_q;
  logic signed [DW-1:0] ops_q [sst_pkg::NUM_TAPS];
  sst_pkg::tag_t op_tag_q;

  // effective grid size
  always_comb begin
    if (geom_i.width < sst_pkg::GW_W'(sst_pkg::MIN_DIM)) begin
      w_eff = EW'(sst_pkg::MIN_DIM);
    end else if (EW'(geom_i.width) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(geom_i.width);
    end
    h_eff = (geom_i.height < HW'(sst_pkg::MIN_DIM)) ? HW'(sst_pkg::MIN_DIM) : geom_i.height;
  end

  // position of the current sample and the next counter values
  always_comb begin
    c_wrap = (EW'(col_q) >= w_eff);
    cur_c  = c_wrap ? '0 : col_q;
    r_inc  = c_wrap ? ({1'b0, row_q} + 17'd1) : {1'b0, row_q};
    cur_r  = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[HW-1:0];
    c_nx   = EW'(cur_c) + EW'(1);
    r_nx   = {1'b0, cur_r} + 17'd1;
    if (c_nx >= w_eff) begin
      col_d = '0;
      row_d = (r_nx >= {1'b0, h_eff}) ? '0 : r_nx[HW-1:0];
    end else begin
      col_d = c_nx[CW-1:0];
      row_d = cur_r;
    end
    emit_o = (cur_r >= HW'(4)) && (EW'(cur_c) >= EW'(4));
    last   = (cur_r == h_eff - HW'(1)) && (EW'(cur_c) == w_eff - EW'(1));
    c_m2   = EW'(cur_c) - EW'(2);
  end

  // counters and first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_emit_q     <= emit_o;
      s1_addr_q     <= cur_c;
      s1_slot_q     <= cur_r[1:0];
      s1_sample_q   <= sample_i;
      s1_tag_q.row  <= cur_r - HW'(2);
      s1_tag_q.col  <= c_m2[sst_pkg::COL_W-1:0];
      s1_tag_q.last <= last;
    end
  end

  // line store, one lane per row slot
  sst_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (wdata),
    .re_i    (accept_i),
    .raddr_i (cur_c),
    .rdata_o (rdata)
  );

  // column vector and write-back merge
  always_comb begin
    logic [1:0] sk;
    for (int k = 0; k < 4; k++) begin
      sk     = 2'(s1_slot_q + 2'(k));
      col[k] = rdata[DW*sk +: DW];
    end
    col[4] = s1_sample_q;
    for (int k = 0; k < 4; k++) begin
      wdata[DW*k +: DW] = (s1_slot_q == 2'(k)) ? s1_sample_q : rdata[DW*k +: DW];
    end
  end

  // window taps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) crt_q[k] <= '0;
      for (int k = 0; k < 8; k++) cdt_q[k] <= '0;
    end else if (s1_valid_q) begin
      for (int k = 0; k < 4; k++) crt_q[k] <= crt_q[k+1];
      crt_q[4] <= col[2];
      cdt_q[1] <= cdt_q[0];
      cdt_q[0] <= col[0];
      cdt_q[3] <= cdt_q[2];
      cdt_q[2] <= col[1];
      cdt_q[5] <= cdt_q[4];
      cdt_q[4] <= col[3];
      cdt_q[7] <= cdt_q[6];
      cdt_q[6] <= col[4];
    end
  end

  // operand stage, weights 0.1 .. 0.9 in order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else begin
      op_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      ops_q[0] <= cdt_q[1];
      ops_q[1] <= cdt_q[3];
      ops_q[2] <= crt_q[1];
      ops_q[3] <= crt_q[2];
      ops_q[4] <= crt_q[3];
      ops_q[5] <= crt_q[4];
      ops_q[6] <= col[2];
      ops_q[7] <= cdt_q[5];
      ops_q[8] <= cdt_q[7];
      op_tag_q <= s1_tag_q;
    end
  end

  assign op_valid_o = op_valid_q;
  assign ops_o      = ops_q;
  assign op_tag_o   = op_tag_q;

endmodule

FILE: src/sst_mac.sv
// ----------------------------------------------------------------------------
// sst_mac
// nine constant-weight products, adder tree, rounding and saturation
// ----------------------------------------------------------------------------
module sst_mac #(
  parameter int FRAC_BITS = sst_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              op_valid_i,
  input  logic signed [sst_pkg::DATA_W-1:0] ops_i [sst_pkg::NUM_TAPS],
  input  sst_pkg::tag_t                     op_tag_i,
  output logic                              res_valid_o,
  output logic signed [sst_pkg::DATA_W-1:0] res_value_o,
  output sst_pkg::tag_t                     res_tag_o
);

  localparam int DW   = sst_pkg::DATA_W;
  localparam int NT   = sst_pkg::NUM_TAPS;
  localparam int WT_W = FRAC_BITS;
  localparam int PW   = DW + WT_W + 1;
  localparam int AW   = PW + 4;
  localparam int QW   = AW - FRAC_BITS;

  logic signed [PW-1:0] prod_d [NT];
  logic signed [PW-1:0] prod_q [NT];
  logic signed [AW-1:0] part_q [3];
  logic signed [AW-1:0] acc_q;
  logic signed [QW-1:0] quo;
  logic                 v3_q, v4_q, v5_q;
  sst_pkg::tag_t        tag3_q, tag4_q, tag5_q;

  // products against the fixed weights
  always_comb begin
    logic [WT_W-1:0] wt;
    for (int i = 0; i < NT; i++) begin
      wt        = WT_W'(sst_pkg::weight(i + 1, FRAC_BITS));
      prod_d[i] = PW'(ops_i[i]) * PW'(signed'({1'b0, wt}));
    end
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= op_valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // product, partial sum and total stages with the rounding bias
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    tag3_q <= op_tag_i;
    for (int j = 0; j < 3; j++) begin
      part_q[j] <= AW'(prod_q[3*j]) + AW'(prod_q[3*j+1]) + AW'(prod_q[3*j+2]);
    end
    tag4_q <= tag3_q;
    acc_q  <= part_q[0] + part_q[1] + part_q[2] + (AW'(1) <<< (FRAC_BITS - 1));
    tag5_q <= tag4_q;
  end

  // floor shift and clamp to the 32-bit range
  always_comb begin
    quo = QW'(acc_q >>> FRAC_BITS);
    if (quo > QW'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
      res_value_o = {1'b0, {(DW-1){1'b1}}};
    end else if (quo < -QW'(signed'({1'b0, 1'b1, {(DW-1){1'b0}}}))) begin
      res_value_o = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res_value_o = quo[DW-1:0];
    end
  end

  assign res_valid_o = v5_q;
  assign res_tag_o   = tag5_q;

endmodule

FILE: src/sst_outq.sv
// ----------------------------------------------------------------------------
// sst_outq
// result queue with a credit count that covers results still in flight
// ----------------------------------------------------------------------------
module sst_outq #(
  parameter int DEPTH = sst_pkg::OUTQ_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              reserve_i,
  output logic                              full_o,
  input  logic                              push_i,
  input  logic signed [sst_pkg::DATA_W-1:0] push_value_i,
  input  sst_pkg::tag_t                     push_tag_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sst_pkg::DATA_W-1:0] out_value_o,
  output sst_pkg::tag_t                     out_tag_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [sst_pkg::DATA_W-1:0] val_q [DEPTH];
  sst_pkg::tag_t                     tag_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, credit_q;
  logic             pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_value_o = val_q[rd_q];
  assign out_tag_o   = tag_q[rd_q];
  assign full_o      = (credit_q >= CNT_W'(DEPTH));

  // pointers, fill and credit counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q     <= '0;
      rd_q     <= '0;
      cnt_q    <= '0;
      credit_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      cnt_q    <= cnt_q + CNT_W'(push_i) - CNT_W'(pop);
      credit_q <= credit_q + CNT_W'(reserve_i) - CNT_W'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      val_q[wr_q] <= push_value_i;
      tag_q[wr_q] <= push_tag_i;
    end
  end

endmodule

FILE: src/stencil_star_9point_2d.sv
// ----------------------------------------------------------------------------
// stencil_star_9point_2d
// 9-point star stencil over a raster-order stream of Q16.16 grid samples
// ----------------------------------------------------------------------------
// Samples enter on in_valid_i / in_stall_o, one request per grid cell in raster
// order. For every center at least two cells from each edge one result leaves
// on out_valid_o / out_stall_i with the rounded, saturated sum, its center row
// and column and a flag on the final interior result of the frame. Border
// cells give no result.
// Throughput is one sample per cycle while in_stall_o is low. A result passes,
// in order, the line-store read, the window taps, then the product, partial sum
// and total registers and the queue write before it leaves on out_valid_o.
// The line store is a single ram, four rows wide, read and written back once
// per sample. Results wait in an eight-entry queue; in_stall_o rises when every
// queue slot is claimed by a result that is still in flight or queued.
// grid_width and grid_height go on the cfg channel (index 0 and 1); the user must
// write them only while the block is idle, which the block does not enforce; cfg_ready_o is always high.
// Reset clears counters, taps, queue and the pipeline, and sets both sizes
// to 4100. Line-store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module stencil_star_9point_2d #(
  parameter int MAX_WIDTH = sst_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = sst_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sst_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sst_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [sst_pkg::DATA_W-1:0]     sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [sst_pkg::DATA_W-1:0]     result_value_o,
  output logic [sst_pkg::ROW_W-1:0]             center_row_o,
  output logic [sst_pkg::COL_W-1:0]             center_col_o,
  output logic                                  last_of_frame_o
);

  sst_pkg::geom_t geom_q;
  logic           accept, emit, full;
  logic           op_valid, res_valid;
  logic signed [sst_pkg::DATA_W-1:0] ops [sst_pkg::NUM_TAPS];
  logic signed [sst_pkg::DATA_W-1:0] res_value;
  sst_pkg::tag_t  op_tag, res_tag, out_tag;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.width  <= sst_pkg::GRID_WIDTH_RST;
      geom_q.height <= sst_pkg::GRID_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sst_pkg::REG_GRID_WIDTH: begin
          geom_q.width <= cfg_data_i[sst_pkg::GW_W-1:0];
        end
        sst_pkg::REG_GRID_HEIGHT: begin
          geom_q.height <= cfg_data_i[sst_pkg::GH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // line store and window
  sst_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom_q),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .emit_o     (emit),
    .op_valid_o (op_valid),
    .ops_o      (ops),
    .op_tag_o   (op_tag)
  );

  // weighted sum
  sst_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .ops_i       (ops),
    .op_tag_i    (op_tag),
    .res_valid_o (res_valid),
    .res_value_o (res_value),
    .res_tag_o   (res_tag)
  );

  // result queue
  sst_outq #(
    .DEPTH (sst_pkg::OUTQ_DEPTH_DEF)
  ) u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reserve_i    (accept && emit),
    .full_o       (full),
    .push_i       (res_valid),
    .push_value_i (res_value),
    .push_tag_i   (res_tag),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (result_value_o),
    .out_tag_o    (out_tag)
  );

  assign center_row_o    = out_tag.row;
  assign center_col_o    = out_tag.col;
  assign last_of_frame_o = out_tag.last;

endmodule

FILE: src/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// port-level checks on the stencil block, attached by bind
// ----------------------------------------------------------------------------
`include "stencil_star_9point_2d_defines.svh"

module sst_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [sst_pkg::DATA_W-1:0] result_value_o,
  input logic [sst_pkg::ROW_W-1:0]         center_row_o,
  input logic [sst_pkg::COL_W-1:0]         center_col_o,
  input logic                              last_of_frame_o
);

  logic [sst_pkg::DATA_W+sst_pkg::ROW_W+sst_pkg::COL_W:0] out_word;

  // whole result payload in one word
  assign out_word = {result_value_o, center_row_o, center_col_o, last_of_frame_o};

  // a stalled result stays offered
  `SST_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result keeps its payload
  `SST_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word))

  // input back-pressure only while results are queued
  `SST_ASSERT_NOW(a_stall_queued, in_stall_o, out_valid_o)

  // a fresh result from an empty queue traces back to an accepted sample
  `SST_ASSERT_NOW(a_first_latency, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 6))

endmodule

bind stencil_star_9point_2d sst_checker u_sst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_value_o  (result_value_o),
  .center_row_o    (center_row_o),
  .center_col_o    (center_col_o),
  .last_of_frame_o (last_of_frame_o)
);
